@@ rtl/core/thp_pkg.sv @@
// shared types and constants of the sensor compensation unit
// no dependencies; imported by every module of the block
`default_nettype none

package thp_pkg;

    localparam int unsigned S_TDATA_W  = 56;
    localparam int unsigned M_TDATA_W  = 120;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    // pressure divider: one quotient bit per stage
    localparam int unsigned DIV_W      = 64;
    localparam int unsigned DIV_STAGES = 64;

    // humidity accumulator ceiling (100 percent before the final shift)
    localparam logic [31:0] HUM_CEIL = 32'd419430400;

    typedef enum logic [2:0] {
        REG_TEMP       = 3'd0,
        REG_PRESS_LOW  = 3'd1,
        REG_PRESS_MID  = 3'd2,
        REG_PRESS_HIGH = 3'd3,
        REG_HUM_FIRST  = 3'd4,
        REG_HUM_SECOND = 3'd5
    } thp_reg_t;

    // values that ride along the divider
    typedef struct packed {
        logic [31:0] tc;
        logic [31:0] tf;
        logic [31:0] hv2;
        logic [31:0] ss;
        logic        neg;
        logic        zero;
    } thp_side_t;

    // values that ride along the pressure finishing stages
    typedef struct packed {
        logic [31:0] tc;
        logic [31:0] tf;
        logic [16:0] hum;
        logic        zero;
    } thp_tail_t;

endpackage

`default_nettype wire

@@ rtl/core/thp_div.sv @@
// pipelined unsigned restoring divider, 64 bits, one quotient bit per stage
// depends on thp_pkg (widths, side-band struct)
`default_nettype none

module thp_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [thp_pkg::DIV_W-1:0]      in_num,
    input  logic [thp_pkg::DIV_W-1:0]      in_den,
    input  thp_pkg::thp_side_t             in_side,
    output logic                           out_valid,
    output logic [thp_pkg::DIV_W-1:0]      out_quo,
    output thp_pkg::thp_side_t             out_side
);
    import thp_pkg::*;

    logic [DIV_W-1:0] rem_reg  [DIV_STAGES];
    logic [DIV_W-1:0] nq_reg   [DIV_STAGES];
    logic [DIV_W-1:0] den_reg  [DIV_STAGES];
    thp_side_t        side_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] nq_in;
        logic [DIV_W-1:0] den_in;
        thp_side_t        side_in;
        logic             vld_in;
        logic [DIV_W:0]   trial;
        logic             qbit;
        logic [DIV_W-1:0] rem_next;
        logic [DIV_W-1:0] nq_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign nq_in   = in_num;
            assign den_in  = in_den;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign nq_in   = nq_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // shift in the next dividend bit, try the subtract
        assign trial    = {rem_in, nq_in[DIV_W-1]} - {1'b0, den_in};
        assign qbit     = !trial[DIV_W];
        assign rem_next = qbit ? trial[DIV_W-1:0] : {rem_in[DIV_W-2:0], nq_in[DIV_W-1]};
        assign nq_next  = {nq_in[DIV_W-2:0], qbit};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                nq_reg[k]   <= nq_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_quo   = nq_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/core/thp_sensor_compensation_unit.sv @@
// top level of the temperature / pressure / humidity integer compensation unit
// depends on thp_pkg and thp_div (pipelined 64-bit divider)
//
// usage:
//   s_ channel: one raw measurement set per beat, s_tdata = {humidity, pressure,
//   temperature} from bit 0 up; accepted when s_tvalid and s_tready are high
//   m_ channel: one compensated result per input beat, in order
//   cfg channel: writes one calibration word per beat at cfg_index; cfg_ready is
//   always high; write only while no beat is in flight (about 80 cycles idle)
// latency: 80 cycles from an accepted input beat to m_tvalid of its result:
//   10 stages of temperature, pressure and humidity arithmetic, 64 divider stages
//   (one quotient bit each), 5 pressure finishing stages, then the output register
// throughput: one beat per cycle, set by the fully pipelined divider
// reset: aresetn low clears every valid bit and all calibration words to zero;
//   data registers are not cleared
// stall: while m_tready is low and a result waits, the pipeline keeps moving as
//   long as the stage in front of the output register is empty, so bubbles are
//   squeezed out; once it holds a result too, s_tready drops and nothing is lost
`default_nettype none

module thp_sensor_compensation_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // fields from bit 0: raw_temperature(20), raw_pressure(20), raw_humidity(16)
    input  logic [thp_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fields from bit 0: temperature_centi(32), fine_temperature(32),
    // pressure_q24_8(32), humidity_q7_10(17), zero fill(7)
    output logic [thp_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [thp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [thp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import thp_pkg::*;

    // ------------------------------------------------------------------
    // calibration registers
    // ------------------------------------------------------------------
    logic [47:0] temp_reg;
    logic [47:0] plow_reg;
    logic [47:0] pmid_reg;
    logic [47:0] phigh_reg;
    logic [31:0] hfirst_reg;
    logic [31:0] hsecond_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg    <= '0;
            plow_reg    <= '0;
            pmid_reg    <= '0;
            phigh_reg   <= '0;
            hfirst_reg  <= '0;
            hsecond_reg <= '0;
        end else if (cfg_valid) begin
            unique case (thp_reg_t'(cfg_index))
                REG_TEMP:       temp_reg    <= cfg_data;
                REG_PRESS_LOW:  plow_reg    <= cfg_data;
                REG_PRESS_MID:  pmid_reg    <= cfg_data;
                REG_PRESS_HIGH: phigh_reg   <= cfg_data;
                REG_HUM_FIRST:  hfirst_reg  <= cfg_data[31:0];
                REG_HUM_SECOND: hsecond_reg <= cfg_data[31:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // coefficient views; unsigned ones get a zero sign bit
    logic signed [15:0] t2_s, t3_s;
    logic signed [16:0] p1_s;
    logic signed [15:0] p2_s, p3_s, p4_s, p5_s, p6_s, p7_s, p8_s, p9_s;
    logic signed [8:0]  h1_s, h3_s;
    logic signed [15:0] h2_s;
    logic signed [11:0] h5_s;
    logic signed [7:0]  h6_s;

    assign t2_s = $signed(temp_reg[31:16]);
    assign t3_s = $signed(temp_reg[47:32]);
    assign p1_s = $signed({1'b0, plow_reg[15:0]});
    assign p2_s = $signed(plow_reg[31:16]);
    assign p3_s = $signed(plow_reg[47:32]);
    assign p4_s = $signed(pmid_reg[15:0]);
    assign p5_s = $signed(pmid_reg[31:16]);
    assign p6_s = $signed(pmid_reg[47:32]);
    assign p7_s = $signed(phigh_reg[15:0]);
    assign p8_s = $signed(phigh_reg[31:16]);
    assign p9_s = $signed(phigh_reg[47:32]);
    assign h1_s = $signed({1'b0, hfirst_reg[7:0]});
    assign h2_s = $signed(hfirst_reg[23:8]);
    assign h3_s = $signed({1'b0, hfirst_reg[31:24]});
    assign h5_s = $signed(hsecond_reg[23:12]);
    assign h6_s = $signed(hsecond_reg[31:24]);

    // ------------------------------------------------------------------
    // flow control: one enable for the whole pipe, output register apart
    // ------------------------------------------------------------------
    logic       adv;
    logic [9:0] st_vld_reg;     // stages 1..10
    logic [4:0] q_vld_reg;      // finishing stages 1..5
    logic       out_vld_reg;
    logic       div_vld;

    assign adv      = !out_vld_reg || m_tready || !q_vld_reg[4];
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg <= '0;
            q_vld_reg  <= '0;
        end else if (adv) begin
            st_vld_reg <= {st_vld_reg[8:0], s_tvalid};
            q_vld_reg  <= {q_vld_reg[3:0], div_vld};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: temperature products
    // ------------------------------------------------------------------
    logic [19:0]        raw_t, raw_p;
    logic [15:0]        raw_h;
    logic signed [17:0] diff_a;
    logic signed [16:0] diff_d;
    logic signed [33:0] pa_full, dd_full;

    assign raw_t  = s_tdata[19:0];
    assign raw_p  = s_tdata[39:20];
    assign raw_h  = s_tdata[55:40];
    assign diff_a = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, temp_reg[15:0], 1'b0});
    assign diff_d = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, temp_reg[15:0]});
    assign pa_full = diff_a * t2_s;
    assign dd_full = diff_d * diff_d;

    logic [31:0] st1_pa_reg, st1_dd_reg;
    logic [19:0] st1_rp_reg;
    logic [15:0] st1_rh_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_pa_reg <= pa_full[31:0];
            st1_dd_reg <= dd_full[31:0];
            st1_rp_reg <= raw_p;
            st1_rh_reg <= raw_h;
        end
    end

    // stage 2
    logic signed [31:0] a_sh, dd_sh;
    logic signed [47:0] bt_full;

    assign a_sh    = $signed(st1_pa_reg) >>> 11;
    assign dd_sh   = $signed(st1_dd_reg) >>> 12;
    assign bt_full = dd_sh * t3_s;

    logic signed [31:0] st2_a_reg;
    logic [31:0]        st2_bt_reg;
    logic [19:0]        st2_rp_reg;
    logic [15:0]        st2_rh_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st2_a_reg  <= a_sh;
            st2_bt_reg <= bt_full[31:0];
            st2_rp_reg <= st1_rp_reg;
            st2_rh_reg <= st1_rh_reg;
        end
    end

    // stage 3: fine temperature
    logic signed [31:0] bt_sh, tf_next;

    assign bt_sh   = $signed(st2_bt_reg) >>> 14;
    assign tf_next = st2_a_reg + bt_sh;

    logic [31:0] st3_tf_reg;
    logic [19:0] st3_rp_reg;
    logic [15:0] st3_rh_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st3_tf_reg <= tf_next;
            st3_rp_reg <= st2_rp_reg;
            st3_rh_reg <= st2_rh_reg;
        end
    end

    // stage 4: centidegrees, pressure and humidity offsets
    logic [31:0]        tc5;
    logic signed [31:0] tc_sh;
    logic signed [33:0] x0_next;

    assign tc5     = st3_tf_reg * 32'd5 + 32'd128;
    assign tc_sh   = $signed(tc5) >>> 8;
    assign x0_next = $signed({{2{st3_tf_reg[31]}}, st3_tf_reg}) - 34'sd128000;

    logic [31:0]        st4_tc_reg, st4_tf_reg;
    logic signed [33:0] st4_x0_reg;
    logic signed [31:0] st4_v_reg;
    logic [19:0]        st4_rp_reg;
    logic [15:0]        st4_rh_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st4_tc_reg <= tc_sh;
            st4_tf_reg <= st3_tf_reg;
            st4_x0_reg <= x0_next;
            st4_v_reg  <= st3_tf_reg - 32'd76800;
            st4_rp_reg <= st3_rp_reg;
            st4_rh_reg <= st3_rh_reg;
        end
    end

    // stage 5: first pressure and humidity products
    logic signed [67:0] xx_full;
    logic signed [49:0] xp5_full, xp2_full;
    logic signed [43:0] h5v_full;
    logic signed [39:0] vh6_full;
    logic signed [40:0] vh3_full;
    logic [31:0]        hu_pre;

    assign xx_full  = st4_x0_reg * st4_x0_reg;
    assign xp5_full = st4_x0_reg * p5_s;
    assign xp2_full = st4_x0_reg * p2_s;
    assign h5v_full = h5_s * st4_v_reg;
    assign vh6_full = st4_v_reg * h6_s;
    assign vh3_full = st4_v_reg * h3_s;
    assign hu_pre   = {2'b00, st4_rh_reg, 14'd0} - {hsecond_reg[11:0], 20'd0}
                    - h5v_full[31:0] + 32'd16384;

    logic [63:0]        st5_xx_reg;
    logic signed [49:0] st5_xp5_reg, st5_xp2_reg;
    logic [31:0]        st5_hu_reg, st5_vh6_reg, st5_vh3_reg;
    logic [31:0]        st5_tc_reg, st5_tf_reg;
    logic [19:0]        st5_rp_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st5_xx_reg  <= xx_full[63:0];
            st5_xp5_reg <= xp5_full;
            st5_xp2_reg <= xp2_full;
            st5_hu_reg  <= hu_pre;
            st5_vh6_reg <= vh6_full[31:0];
            st5_vh3_reg <= vh3_full[31:0];
            st5_tc_reg  <= st4_tc_reg;
            st5_tf_reg  <= st4_tf_reg;
            st5_rp_reg  <= st4_rp_reg;
        end
    end

    // stage 6
    logic signed [79:0] ya_full, xa_full;
    logic signed [31:0] u_sh, vh6_sh, vh3_off;
    logic signed [63:0] w1_full;

    assign ya_full = $signed(st5_xx_reg) * p6_s;
    assign xa_full = $signed(st5_xx_reg) * p3_s;
    assign u_sh    = $signed(st5_hu_reg) >>> 15;
    assign vh6_sh  = $signed(st5_vh6_reg) >>> 10;
    assign vh3_off = ($signed(st5_vh3_reg) >>> 11) + 32'sd32768;
    assign w1_full = vh6_sh * vh3_off;

    logic [63:0]        st6_ya_reg, st6_xa_reg;
    logic signed [49:0] st6_xp5_reg, st6_xp2_reg;
    logic signed [31:0] st6_u_reg;
    logic [31:0]        st6_w1_reg, st6_tc_reg, st6_tf_reg;
    logic [19:0]        st6_rp_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st6_ya_reg  <= ya_full[63:0];
            st6_xa_reg  <= xa_full[63:0];
            st6_xp5_reg <= st5_xp5_reg;
            st6_xp2_reg <= st5_xp2_reg;
            st6_u_reg   <= u_sh;
            st6_w1_reg  <= w1_full[31:0];
            st6_tc_reg  <= st5_tc_reg;
            st6_tf_reg  <= st5_tf_reg;
            st6_rp_reg  <= st5_rp_reg;
        end
    end

    // stage 7: pressure sums
    logic [63:0]        xp5_ext, xp2_ext, p4_ext, y_next, x1_next;
    logic signed [63:0] xa_sh;
    logic signed [31:0] w1_sh;

    assign xp5_ext = {{14{st6_xp5_reg[49]}}, st6_xp5_reg};
    assign xp2_ext = {{14{st6_xp2_reg[49]}}, st6_xp2_reg};
    assign p4_ext  = {{48{p4_s[15]}}, p4_s};
    assign y_next  = st6_ya_reg + (xp5_ext << 17) + (p4_ext << 35);
    assign xa_sh   = $signed(st6_xa_reg) >>> 8;
    assign x1_next = xa_sh + (xp2_ext << 12);
    assign w1_sh   = $signed(st6_w1_reg) >>> 10;

    logic [63:0]        st7_y_reg;
    logic signed [63:0] st7_x1_reg;
    logic signed [31:0] st7_u_reg, st7_w2_reg;
    logic [31:0]        st7_tc_reg, st7_tf_reg;
    logic [19:0]        st7_rp_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st7_y_reg  <= y_next;
            st7_x1_reg <= x1_next;
            st7_u_reg  <= st6_u_reg;
            st7_w2_reg <= w1_sh + 32'sd2097152;
            st7_tc_reg <= st6_tc_reg;
            st7_tf_reg <= st6_tf_reg;
            st7_rp_reg <= st6_rp_reg;
        end
    end

    // stage 8: divisor product, dividend base
    logic signed [63:0] x1_off;
    logic signed [80:0] x2p_full;
    logic [20:0]        prw;
    logic signed [47:0] w2h2;
    logic [31:0]        w3_sum;
    logic signed [31:0] w3_sh;

    assign x1_off   = st7_x1_reg + 64'sh0000_8000_0000_0000;
    assign x2p_full = x1_off * p1_s;
    assign prw      = 21'd1048576 - {1'b0, st7_rp_reg};
    assign w2h2     = st7_w2_reg * h2_s;
    assign w3_sum   = w2h2[31:0] + 32'd8192;
    assign w3_sh    = $signed(w3_sum) >>> 14;

    logic [63:0]        st8_x2p_reg, st8_num0_reg;
    logic signed [31:0] st8_u_reg, st8_w3_reg;
    logic [31:0]        st8_tc_reg, st8_tf_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st8_x2p_reg  <= x2p_full[63:0];
            st8_num0_reg <= {12'd0, prw, 31'd0} - st7_y_reg;
            st8_u_reg    <= st7_u_reg;
            st8_w3_reg   <= w3_sh;
            st8_tc_reg   <= st7_tc_reg;
            st8_tf_reg   <= st7_tf_reg;
        end
    end

    // stage 9: divisor, scaled dividend, humidity product
    logic signed [63:0] x2_sh;
    logic signed [63:0] hv2_full;

    assign x2_sh    = $signed(st8_x2p_reg) >>> 33;
    assign hv2_full = st8_u_reg * st8_w3_reg;

    logic [63:0] st9_x2_reg, st9_num_reg;
    logic [31:0] st9_hv2_reg, st9_tc_reg, st9_tf_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st9_x2_reg  <= x2_sh;
            st9_num_reg <= st8_num0_reg * 64'd3125;
            st9_hv2_reg <= hv2_full[31:0];
            st9_tc_reg  <= st8_tc_reg;
            st9_tf_reg  <= st8_tf_reg;
        end
    end

    // stage 10: magnitudes for the divider, humidity square
    logic signed [31:0] s_sh;
    logic signed [63:0] ss_full;
    thp_side_t          side_next;

    assign s_sh    = $signed(st9_hv2_reg) >>> 15;
    assign ss_full = s_sh * s_sh;

    always_comb begin
        side_next.tc   = st9_tc_reg;
        side_next.tf   = st9_tf_reg;
        side_next.hv2  = st9_hv2_reg;
        side_next.ss   = ss_full[31:0];
        side_next.neg  = st9_num_reg[63] ^ st9_x2_reg[63];
        side_next.zero = (st9_x2_reg == 64'd0);
    end

    logic [63:0] st10_na_reg, st10_da_reg;
    thp_side_t   st10_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st10_na_reg   <= st9_num_reg[63] ? (64'd0 - st9_num_reg) : st9_num_reg;
            st10_da_reg   <= st9_x2_reg[63] ? (64'd0 - st9_x2_reg) : st9_x2_reg;
            st10_side_reg <= side_next;
        end
    end

    // ------------------------------------------------------------------
    // divider: quotient magnitude, truncating
    // ------------------------------------------------------------------
    logic [63:0] div_quo;
    thp_side_t   div_side;

    thp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (st_vld_reg[9]),
        .in_num    (st10_na_reg),
        .in_den    (st10_da_reg),
        .in_side   (st10_side_reg),
        .out_valid (div_vld),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // finishing stage 1: signed quotient, humidity product
    logic signed [31:0] ss_sh;
    logic signed [40:0] hm_full;

    assign ss_sh   = $signed(div_side.ss) >>> 7;
    assign hm_full = ss_sh * h1_s;

    logic signed [63:0] q1_p_reg;
    logic [31:0]        q1_hm_reg;
    thp_side_t          q1_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            q1_p_reg    <= div_side.neg ? (64'd0 - div_quo) : div_quo;
            q1_hm_reg   <= hm_full[31:0];
            q1_side_reg <= div_side;
        end
    end

    // finishing stage 2: pressure products, humidity clamp
    logic signed [63:0] ps1;
    logic signed [79:0] m1_full, p8p_full;
    logic signed [31:0] hm_sh;
    logic [31:0]        vf, vclamp;
    thp_tail_t          tail_next;

    assign ps1      = q1_p_reg >>> 13;
    assign m1_full  = ps1 * p9_s;
    assign p8p_full = q1_p_reg * p8_s;
    assign hm_sh    = $signed(q1_hm_reg) >>> 4;
    assign vf       = q1_side_reg.hv2 - hm_sh;

    always_comb begin
        priority if (vf[31]) begin
            vclamp = '0;
        end else if (vf > HUM_CEIL) begin
            vclamp = HUM_CEIL;
        end else begin
            vclamp = vf;
        end
        tail_next.tc   = q1_side_reg.tc;
        tail_next.tf   = q1_side_reg.tf;
        tail_next.hum  = vclamp[28:12];
        tail_next.zero = q1_side_reg.zero;
    end

    logic [63:0]        q2_m1_reg, q2_p8p_reg;
    logic signed [63:0] q2_p_reg;
    thp_tail_t          q2_tail_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            q2_m1_reg   <= m1_full[63:0];
            q2_p8p_reg  <= p8p_full[63:0];
            q2_p_reg    <= q1_p_reg;
            q2_tail_reg <= tail_next;
        end
    end

    // finishing stage 3: 64 x 64 low product as three 32 x 32 partials
    logic signed [63:0] ps2;
    logic [63:0]        ll_full, lh_full, hl_full;

    assign ps2     = q2_p_reg >>> 13;
    assign ll_full = q2_m1_reg[31:0] * ps2[31:0];
    assign lh_full = q2_m1_reg[31:0] * ps2[63:32];
    assign hl_full = q2_m1_reg[63:32] * ps2[31:0];

    logic [63:0] q3_ll_reg, q3_p8p_reg, q3_p_reg;
    logic [31:0] q3_lh_reg, q3_hl_reg;
    thp_tail_t   q3_tail_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            q3_ll_reg   <= ll_full;
            q3_lh_reg   <= lh_full[31:0];
            q3_hl_reg   <= hl_full[31:0];
            q3_p8p_reg  <= q2_p8p_reg;
            q3_p_reg    <= q2_p_reg;
            q3_tail_reg <= q2_tail_reg;
        end
    end

    // finishing stage 4
    logic [31:0] mid_sum;

    assign mid_sum = q3_lh_reg + q3_hl_reg;

    logic [63:0] q4_m2_reg, q4_p8p_reg, q4_p_reg;
    thp_tail_t   q4_tail_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            q4_m2_reg   <= q3_ll_reg + {mid_sum, 32'd0};
            q4_p8p_reg  <= q3_p8p_reg;
            q4_p_reg    <= q3_p_reg;
            q4_tail_reg <= q3_tail_reg;
        end
    end

    // finishing stage 5
    logic signed [63:0] m2_sh, p8p_sh;

    assign m2_sh  = $signed(q4_m2_reg) >>> 25;
    assign p8p_sh = $signed(q4_p8p_reg) >>> 19;

    logic [63:0] q5_sum_reg;
    thp_tail_t   q5_tail_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            q5_sum_reg  <= q4_p_reg + m2_sh + p8p_sh;
            q5_tail_reg <= q4_tail_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register, loads whenever it is free
    // ------------------------------------------------------------------
    logic signed [63:0] sum_sh;
    logic [31:0]        press_next;
    logic [31:0]        press_reg, tc_reg, tf_reg;
    logic [16:0]        hum_reg;
    logic               out_load;

    assign sum_sh     = $signed(q5_sum_reg) >>> 8;
    assign press_next = q5_tail_reg.zero ? 32'd0
                      : (sum_sh[31:0] + {{12{p7_s[15]}}, p7_s, 4'd0});
    assign out_load   = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= q_vld_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            tc_reg    <= q5_tail_reg.tc;
            tf_reg    <= q5_tail_reg.tf;
            press_reg <= press_next;
            hum_reg   <= q5_tail_reg.hum;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, hum_reg, press_reg, tf_reg, tc_reg};

endmodule

`default_nettype wire

@@ rtl/core/thp_checker.sv @@
// port-level checks for the compensation unit, bound to the top level
// depends on thp_pkg (widths)
`default_nettype none

module thp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic [thp_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [thp_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [thp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [thp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import thp_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // with an empty output register the input side is never blocked
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // humidity clamped, fill bits zero
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[112:96] <= 17'd102400) && (m_tdata[119:113] == 7'd0))
        else $error("humidity out of range");

endmodule

bind thp_sensor_compensation_unit thp_checker u_thp_checker (.*);

`default_nettype wire
